>>> rtl/cmta_pkg.sv
// ----------------------------------------------------------------------------
// Cube map texel addressing package
// Shared widths, face codes and pipeline payload types.
// ----------------------------------------------------------------------------
package cmta_pkg;

  localparam int unsigned DirW      = 16;  // Q1.15 direction component
  localparam int unsigned TexW      = 12;  // texel index
  localparam int unsigned FracW     = 16;  // Q0.16 blend fraction
  localparam int unsigned MagW      = 17;  // magnitude, offset sum, divisor
  localparam int unsigned QuoW      = TexW + FracW;  // quotient bits
  localparam int unsigned NumW      = QuoW;          // product (s + m) * L
  localparam int unsigned DivStep   = 2;   // quotient bits per stage
  localparam int unsigned DivStages = QuoW / DivStep;

  localparam logic [TexW-1:0] LastTexelRst = TexW'(255);

  typedef enum logic {
    CFG_LAST_TEXEL = 1'b0,
    CFG_BILINEAR   = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    FACE_PX = 3'd0,
    FACE_NX = 3'd1,
    FACE_PY = 3'd2,
    FACE_NY = 3'd3,
    FACE_PZ = 3'd4,
    FACE_NZ = 3'd5
  } face_e;

  // per-word side data that rides along the divider
  typedef struct packed {
    face_e            face;
    logic             zero;
    logic [MagW-1:0]  den;
  } item_t;

  // one restoring-division lane: partial remainder and shifting word
  // (remaining dividend bits on top, quotient bits shifting in below)
  typedef struct packed {
    logic [MagW-1:0]  rem;
    logic [QuoW-1:0]  bits;
  } div_lane_t;

endpackage

>>> rtl/cmta_select.sv
// ----------------------------------------------------------------------------
// Cube map face select stage
// Picks the major axis, projects the minor components onto u and v, and
// registers the offset coordinates (s + m) with the divisor 2m.
// ----------------------------------------------------------------------------
module cmta_select (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [cmta_pkg::DirW-1:0]     dir_x_i,
  input  logic [cmta_pkg::DirW-1:0]     dir_y_i,
  input  logic [cmta_pkg::DirW-1:0]     dir_z_i,
  output cmta_pkg::item_t               item_o,
  output logic [cmta_pkg::MagW-1:0]     sum_u_o,
  output logic [cmta_pkg::MagW-1:0]     sum_v_o
);
  import cmta_pkg::*;

  logic [MagW-1:0] xs, ys, zs, xn, yn, zn;
  logic [MagW-1:0] ax, ay, az, m;
  logic [MagW-1:0] su, sv;
  logic [MagW:0]   tu, tv;
  face_e           face;
  item_t           item_d;

  // magnitudes, major axis and projection
  always_comb begin
    xs = {dir_x_i[DirW-1], dir_x_i};
    ys = {dir_y_i[DirW-1], dir_y_i};
    zs = {dir_z_i[DirW-1], dir_z_i};
    xn = MagW'(0) - xs;
    yn = MagW'(0) - ys;
    zn = MagW'(0) - zs;
    ax = dir_x_i[DirW-1] ? xn : xs;
    ay = dir_y_i[DirW-1] ? yn : ys;
    az = dir_z_i[DirW-1] ? zn : zs;

    if (ax >= ay && ax >= az) begin
      m    = ax;
      face = dir_x_i[DirW-1] ? FACE_NX : FACE_PX;
    end else if (ay >= az) begin
      m    = ay;
      face = dir_y_i[DirW-1] ? FACE_NY : FACE_PY;
    end else begin
      m    = az;
      face = dir_z_i[DirW-1] ? FACE_NZ : FACE_PZ;
    end

    case (face)
      FACE_PX: begin su = zn; sv = yn; end
      FACE_NX: begin su = zs; sv = yn; end
      FACE_PY: begin su = xs; sv = zs; end
      FACE_NY: begin su = xs; sv = zn; end
      FACE_PZ: begin su = xs; sv = yn; end
      FACE_NZ: begin su = xn; sv = yn; end
      default: begin su = xs; sv = ys; end
    endcase

    tu = {su[MagW-1], su} + {1'b0, m};
    tv = {sv[MagW-1], sv} + {1'b0, m};

    item_d.face = face;
    item_d.zero = (m == '0);
    item_d.den  = {m[MagW-2:0], 1'b0};
  end

  // hold the stage while stalled
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_o  <= item_d;
      sum_u_o <= tu[MagW-1:0];
      sum_v_o <= tv[MagW-1:0];
    end
  end

endmodule

>>> rtl/cmta_div_stage.sv
// ----------------------------------------------------------------------------
// Cube map divider stage
// Runs DivStep restoring-division steps on the u and v lanes and registers
// them together with the side data.
// ----------------------------------------------------------------------------
module cmta_div_stage (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  cmta_pkg::item_t       item_i,
  input  cmta_pkg::div_lane_t   u_i,
  input  cmta_pkg::div_lane_t   v_i,
  output cmta_pkg::item_t       item_o,
  output cmta_pkg::div_lane_t   u_o,
  output cmta_pkg::div_lane_t   v_o
);
  import cmta_pkg::*;

  function automatic div_lane_t div_bit(div_lane_t l, logic [MagW-1:0] den);
    logic [MagW:0] t;
    logic [MagW:0] d;
    div_lane_t     r;
    t = {l.rem, l.bits[QuoW-1]};
    d = {1'b0, den};
    if (t >= d) begin
      r.rem  = MagW'(t - d);
      r.bits = {l.bits[QuoW-2:0], 1'b1};
    end else begin
      r.rem  = t[MagW-1:0];
      r.bits = {l.bits[QuoW-2:0], 1'b0};
    end
    return r;
  endfunction

  div_lane_t u_d, v_d;

  // retire DivStep quotient bits per lane
  always_comb begin
    u_d = u_i;
    v_d = v_i;
    for (int k = 0; k < DivStep; k++) begin
      u_d = div_bit(u_d, item_i.den);
      v_d = div_bit(v_d, item_i.den);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_o <= item_i;
      u_o    <= u_d;
      v_o    <= v_d;
    end
  end

endmodule

>>> rtl/cube_map_texel_addressing.sv
// ----------------------------------------------------------------------------
// Cube map texel addressing
// Maps a Q1.15 direction vector to a cube face, texel pair and Q0.16
// bilinear fractions.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i/in_ready_o carries one direction word (dir_x,
//   dir_y, dir_z). Output channel out_valid_o/out_ready_i carries the face,
//   low and high column/row and fractions, or the zero_vector flag.
//   The pipeline has 17 register stages: one face-select stage, one multiply
//   stage, 14 divider stages of two quotient bits each (28-bit quotient:
//   12 integer, 16 fraction) and one output stage.
//   Throughput is one word per cycle while out_ready_i stays high; every
//   stage holds its own valid bit. When the receiver stalls, the output
//   stage holds its word and the stall walks back only through full
//   stages, so empty stages keep filling and in_ready_o drops only once
//   the whole pipeline is full.
//   Reset clears all valid bits, sets last_texel to 255 and bilinear mode
//   on. Write configuration through cfg_we_i/cfg_idx_i/cfg_data_i only while
//   no word is in flight.
// ----------------------------------------------------------------------------
module cube_map_texel_addressing (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [cmta_pkg::TexW-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [cmta_pkg::DirW-1:0]     dir_x_i,
  input  logic [cmta_pkg::DirW-1:0]     dir_y_i,
  input  logic [cmta_pkg::DirW-1:0]     dir_z_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [2:0]                    face_o,
  output logic [cmta_pkg::TexW-1:0]     col_lo_o,
  output logic [cmta_pkg::TexW-1:0]     row_lo_o,
  output logic [cmta_pkg::TexW-1:0]     col_hi_o,
  output logic [cmta_pkg::TexW-1:0]     row_hi_o,
  output logic [cmta_pkg::FracW-1:0]    col_frac_o,
  output logic [cmta_pkg::FracW-1:0]    row_frac_o,
  output logic                          zero_vector_o
);
  import cmta_pkg::*;

  localparam int unsigned NStg = DivStages + 3;
  localparam int unsigned OutS = NStg - 1;

  logic [TexW-1:0]  last_texel_q;
  logic             bilinear_q;
  logic [NStg-1:0]  valid_q;
  logic [NStg:0]    en;

  item_t            sel_item;
  logic [MagW-1:0]  sum_u, sum_v;
  item_t            mul_item_q;
  logic [NumW-1:0]  num_u_q, num_v_q;
  logic [MagW+TexW-1:0] prod_u, prod_v;

  item_t            div_item [DivStages+1];
  div_lane_t        div_u    [DivStages+1];
  div_lane_t        div_v    [DivStages+1];

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_texel_q <= LastTexelRst;
      bilinear_q   <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_LAST_TEXEL: last_texel_q <= cfg_data_i;
        CFG_BILINEAR:   bilinear_q   <= cfg_data_i[0];
        default:        ;
      endcase
    end
  end

  // a stage advances when it is empty or the next one advances
  always_comb begin
    en[NStg] = out_ready_i;
    for (int k = NStg - 1; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = valid_q[OutS];

  // valid bits travel with the words
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NStg; k++) begin
        if (en[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  // stage 0: face select
  cmta_select u_select (
    .clk_i   (clk_i),
    .en_i    (en[0]),
    .dir_x_i (dir_x_i),
    .dir_y_i (dir_y_i),
    .dir_z_i (dir_z_i),
    .item_o  (sel_item),
    .sum_u_o (sum_u),
    .sum_v_o (sum_v)
  );

  // stage 1: scale offsets by the last texel
  assign prod_u = sum_u * last_texel_q;
  assign prod_v = sum_v * last_texel_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      mul_item_q <= sel_item;
      num_u_q    <= prod_u[NumW-1:0];
      num_v_q    <= prod_v[NumW-1:0];
    end
  end

  // seed the divider: the top bits are already below the divisor
  always_comb begin
    div_item[0]   = mul_item_q;
    div_u[0].rem  = MagW'(num_u_q[NumW-1:TexW]);
    div_u[0].bits = {num_u_q[TexW-1:0], {FracW{1'b0}}};
    div_v[0].rem  = MagW'(num_v_q[NumW-1:TexW]);
    div_v[0].bits = {num_v_q[TexW-1:0], {FracW{1'b0}}};
  end

  // stages 2 .. DivStages+1: pipelined restoring division
  for (genvar g = 0; g < DivStages; g++) begin : g_div
    cmta_div_stage u_div (
      .clk_i  (clk_i),
      .en_i   (en[g+2]),
      .item_i (div_item[g]),
      .u_i    (div_u[g]),
      .v_i    (div_v[g]),
      .item_o (div_item[g+1]),
      .u_o    (div_u[g+1]),
      .v_o    (div_v[g+1])
    );
  end

  // output stage: neighbours, nearest mode and zero masking
  item_t            fin_item;
  logic [TexW-1:0]  c_lo, r_lo, c_hi, r_hi;
  logic [FracW-1:0] c_fr, r_fr;

  always_comb begin
    fin_item = div_item[DivStages];
    c_lo = div_u[DivStages].bits[QuoW-1:FracW];
    r_lo = div_v[DivStages].bits[QuoW-1:FracW];
    c_fr = div_u[DivStages].bits[FracW-1:0];
    r_fr = div_v[DivStages].bits[FracW-1:0];
    c_hi = (c_lo >= last_texel_q) ? last_texel_q : c_lo + TexW'(1);
    r_hi = (r_lo >= last_texel_q) ? last_texel_q : r_lo + TexW'(1);
    if (!bilinear_q) begin
      c_hi = c_lo;
      r_hi = r_lo;
      c_fr = '0;
      r_fr = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[OutS]) begin
      zero_vector_o <= fin_item.zero;
      if (fin_item.zero) begin
        face_o     <= '0;
        col_lo_o   <= '0;
        row_lo_o   <= '0;
        col_hi_o   <= '0;
        row_hi_o   <= '0;
        col_frac_o <= '0;
        row_frac_o <= '0;
      end else begin
        face_o     <= fin_item.face;
        col_lo_o   <= c_lo;
        row_lo_o   <= r_lo;
        col_hi_o   <= c_hi;
        row_hi_o   <= r_hi;
        col_frac_o <= c_fr;
        row_frac_o <= r_fr;
      end
    end
  end

  // zero vector words carry a zero face, col_lo, row_hi and col_frac
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_vector_o |-> face_o == '0 && col_lo_o == '0 &&
      row_hi_o == '0 && col_frac_o == '0)
    else $error("zero vector word has nonzero fields");

  // texel indices stay ordered and within the face
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> col_lo_o <= col_hi_o && row_lo_o <= row_hi_o &&
      col_hi_o <= last_texel_q && row_hi_o <= last_texel_q)
    else $error("texel index out of order or beyond last texel");

  // nearest mode gives no blend
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !bilinear_q |-> col_frac_o == '0 && row_frac_o == '0 &&
      col_hi_o == col_lo_o)
    else $error("nearest mode word has blend data");

endmodule

>>> dv/cmta_checker.sv
// ----------------------------------------------------------------------------
// Cube map texel addressing checker
// Watches the direction and result channels, predicts face, texels and
// fractions with exact integer math, and compares result words in order.
// ----------------------------------------------------------------------------
module cmta_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [cmta_pkg::TexW-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [cmta_pkg::DirW-1:0]     dir_x_i,
  input  logic [cmta_pkg::DirW-1:0]     dir_y_i,
  input  logic [cmta_pkg::DirW-1:0]     dir_z_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [2:0]                    face_i,
  input  logic [cmta_pkg::TexW-1:0]     col_lo_i,
  input  logic [cmta_pkg::TexW-1:0]     row_lo_i,
  input  logic [cmta_pkg::TexW-1:0]     col_hi_i,
  input  logic [cmta_pkg::TexW-1:0]     row_hi_i,
  input  logic [cmta_pkg::FracW-1:0]    col_frac_i,
  input  logic [cmta_pkg::FracW-1:0]    row_frac_i,
  input  logic                          zero_vector_i,
  output int                            err_cnt_o,
  output int                            pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import cmta_pkg::*;

  typedef struct packed {
    logic [2:0]       face;
    logic [TexW-1:0]  col_lo;
    logic [TexW-1:0]  row_lo;
    logic [TexW-1:0]  col_hi;
    logic [TexW-1:0]  row_hi;
    logic [FracW-1:0] col_frac;
    logic [FracW-1:0] row_frac;
    logic             zero;
  } texel_addr_t;

  texel_addr_t     addr_q[$];
  logic [TexW-1:0] last_texel;
  logic            bilinear;

  assign pending_o = addr_q.size();

  // map s in [-m, m] onto [0, L]: low texel, clamped neighbor, Q0.16 fraction
  function automatic void map_axis(input longint s, input longint m, input longint lim,
                          output logic [TexW-1:0] lo, output logic [TexW-1:0] hi,
                          output logic [FracW-1:0] frac);
    longint num, den, ip, rem;
    num = (s + m) * lim;
    den = 2 * m;
    ip = num / den;
    rem = num % den;
    lo = TexW'(ip);
    hi = TexW'((ip + 1 < lim) ? ip + 1 : lim);
    frac = FracW'((rem << 16) / den);
    if (!bilinear) begin
      hi = TexW'(ip);
      frac = '0;
    end
  endfunction

  function automatic texel_addr_t predict_addr(logic [DirW-1:0] x, logic [DirW-1:0] y,
                                               logic [DirW-1:0] z);
    texel_addr_t r;
    longint c[3], a[3], m, su, sv;
    face_e f;
    r = '0;
    c[0] = longint'($signed(x));
    c[1] = longint'($signed(y));
    c[2] = longint'($signed(z));
    for (int k = 0; k < 3; k++) a[k] = c[k] < 0 ? -c[k] : c[k];
    m = a[0];
    if (a[1] > m) m = a[1];
    if (a[2] > m) m = a[2];
    if (m == 0) begin
      r.zero = 1'b1;
      return r;
    end
    if (m == a[0]) f = c[0] >= 0 ? FACE_PX : FACE_NX;
    else if (m == a[1]) f = c[1] >= 0 ? FACE_PY : FACE_NY;
    else f = c[2] >= 0 ? FACE_PZ : FACE_NZ;
    case (f)
      FACE_PX: begin su = -c[2]; sv = -c[1]; end
      FACE_NX: begin su =  c[2]; sv = -c[1]; end
      FACE_PY: begin su =  c[0]; sv =  c[2]; end
      FACE_NY: begin su =  c[0]; sv = -c[2]; end
      FACE_PZ: begin su =  c[0]; sv = -c[1]; end
      default: begin su = -c[0]; sv = -c[1]; end
    endcase
    r.face = f;
    map_axis(su, m, longint'(last_texel), r.col_lo, r.col_hi, r.col_frac);
    map_axis(sv, m, longint'(last_texel), r.row_lo, r.row_hi, r.row_frac);
    return r;
  endfunction

  // track registers, queue predictions, compare result words
  always @(posedge clk_i or negedge rst_ni) begin
    texel_addr_t e;
    int          n_err;
    n_err = 0;
    if (!rst_ni) begin
      last_texel <= LastTexelRst;
      bilinear   <= 1'b1;
      err_cnt_o  <= 0;
      addr_q.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_LAST_TEXEL) last_texel <= cfg_data_i;
        else bilinear <= cfg_data_i[0];
      end
      if (in_valid_i && in_ready_i)
        addr_q.push_back(predict_addr(dir_x_i, dir_y_i, dir_z_i));
      if (out_valid_i && out_ready_i) begin
        if (addr_q.size() == 0) begin
          $error("result word with no expectation waiting");
          n_err++;
        end else begin
          e = addr_q.pop_front();
          if (face_i !== e.face) begin
            $error("face exp %0d got %0d", e.face, face_i);
            n_err++;
          end
          if (col_lo_i !== e.col_lo) begin
            $error("col_lo exp %0d got %0d", e.col_lo, col_lo_i);
            n_err++;
          end
          if (row_lo_i !== e.row_lo) begin
            $error("row_lo exp %0d got %0d", e.row_lo, row_lo_i);
            n_err++;
          end
          if (col_hi_i !== e.col_hi) begin
            $error("col_hi exp %0d got %0d", e.col_hi, col_hi_i);
            n_err++;
          end
          if (row_hi_i !== e.row_hi) begin
            $error("row_hi exp %0d got %0d", e.row_hi, row_hi_i);
            n_err++;
          end
          if (col_frac_i !== e.col_frac) begin
            $error("col_frac exp %0d got %0d", e.col_frac, col_frac_i);
            n_err++;
          end
          if (row_frac_i !== e.row_frac) begin
            $error("row_frac exp %0d got %0d", e.row_frac, row_frac_i);
            n_err++;
          end
          if (zero_vector_i !== e.zero) begin
            $error("zero_vector exp %0d got %0d", e.zero, zero_vector_i);
            n_err++;
          end
        end
      end
      err_cnt_o <= err_cnt_o + n_err;
    end
  end

endmodule

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// Cube map texel addressing testbench
// Drives directed and random direction words across several face sizes and
// both filter modes with random idling on both channels; the checker module
// predicts and compares every result word.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import cmta_pkg::*;

  localparam int unsigned Latency  = 17;
  localparam int unsigned WdogMax  = 20000;
  localparam int unsigned NumRand  = 1750;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we = 1'b0;
  logic              cfg_idx = CFG_LAST_TEXEL;
  logic [TexW-1:0]   cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [DirW-1:0]   dir_x = '0, dir_y = '0, dir_z = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [2:0]        face;
  logic [TexW-1:0]   col_lo, row_lo, col_hi, row_hi;
  logic [FracW-1:0]  col_frac, row_frac;
  logic              zero_vector;
  int                err_cnt, pending;
  int                idle_pct = 34;
  int unsigned       quiet_cnt = 0;

  always #10 clk_i = ~clk_i;

  cube_map_texel_addressing u_top (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .dir_x_i(dir_x), .dir_y_i(dir_y), .dir_z_i(dir_z),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .face_o(face), .col_lo_o(col_lo), .row_lo_o(row_lo),
    .col_hi_o(col_hi), .row_hi_o(row_hi),
    .col_frac_o(col_frac), .row_frac_o(row_frac),
    .zero_vector_o(zero_vector)
  );

  cmta_checker u_checker (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .dir_x_i(dir_x), .dir_y_i(dir_y), .dir_z_i(dir_z),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .face_i(face), .col_lo_i(col_lo), .row_lo_i(row_lo),
    .col_hi_i(col_hi), .row_hi_i(row_hi),
    .col_frac_i(col_frac), .row_frac_i(row_frac),
    .zero_vector_i(zero_vector),
    .err_cnt_o(err_cnt), .pending_o(pending)
  );

  // stall the receiver at random
  always @(posedge clk_i) out_ready <= ($urandom_range(99) >= idle_pct);

  // end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cnt <= 0;
    else quiet_cnt <= quiet_cnt + 1;
    if (quiet_cnt > WdogMax) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // send one direction word, idling first at random; valid stays high after
  // acceptance until the next word or an explicit drop
  task automatic send_dir(logic [DirW-1:0] x, logic [DirW-1:0] y, logic [DirW-1:0] z);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    dir_x <= x;
    dir_y <= y;
    dir_z <= z;
    do @(posedge clk_i); while (!in_ready);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [TexW-1:0] val);
    while (pending != 0) @(posedge clk_i);
    repeat (Latency + 2) @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // random component: mostly full range, sometimes extremes or small values
  function automatic logic [DirW-1:0] rand_comp();
    case ($urandom_range(5))
      0: return DirW'($urandom_range(2) == 0 ? 16'h8000 : 16'h7fff);
      1: return DirW'($signed($urandom_range(8)) - 4);
      default: return DirW'($urandom());
    endcase
  endfunction

  task automatic rand_phase(int n);
    logic [DirW-1:0] x, y, z;
    for (int i = 0; i < n; i++) begin
      x = rand_comp();
      y = rand_comp();
      z = rand_comp();
      // force magnitude ties now and then
      if ($urandom_range(9) == 0) y = ($urandom_range(1) != 0) ? -x : x;
      if ($urandom_range(9) == 0) z = ($urandom_range(1) != 0) ? -y : y;
      send_dir(x, y, z);
    end
    // drop valid once the last word is taken
    in_valid <= 1'b0;
  endtask

  initial begin
    logic [TexW-1:0] sizes[6];
    sizes = '{12'd255, 12'd1, 12'd4095, 12'd0, 12'd7, 12'd1000};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: zero vector, axis extremes, ties, far edges
    send_dir(16'h0000, 16'h0000, 16'h0000);
    send_dir(16'h7fff, 16'h0000, 16'h0000);
    send_dir(16'h8000, 16'h0000, 16'h0000);
    send_dir(16'h0000, 16'h7fff, 16'h0000);
    send_dir(16'h0000, 16'h8000, 16'h0000);
    send_dir(16'h0000, 16'h0000, 16'h7fff);
    send_dir(16'h0000, 16'h0000, 16'h8000);
    send_dir(16'h7fff, 16'h7fff, 16'h7fff);
    send_dir(16'h8001, 16'h7fff, 16'h8001);
    send_dir(16'h8000, 16'h8000, 16'h8000);
    send_dir(16'h0000, 16'h8000, 16'h8000);
    send_dir(16'h4000, 16'hc000, 16'h4000);
    send_dir(16'h0001, 16'hffff, 16'h0001);
    send_dir(16'h1234, 16'h7fff, 16'h8001);
    send_dir(16'hffff, 16'h0000, 16'h0000);
    send_dir(16'h5555, 16'haaab, 16'h2000);

    // long stretch without idling
    idle_pct = 0;
    rand_phase(200);
    idle_pct = 34;

    // sweep face sizes and filter modes, extremes included
    for (int p = 0; p < 6; p++) begin
      write_reg(CFG_LAST_TEXEL, sizes[p]);
      write_reg(CFG_BILINEAR, TexW'(p % 2));
      if (p == 3) send_dir(16'h1000, 16'h2000, 16'h8000);
      rand_phase(NumRand / 8);
    end
    write_reg(CFG_BILINEAR, TexW'(1));
    rand_phase(NumRand / 8);

    while (pending != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
    if (err_cnt == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

>>> sim.f
rtl/cmta_pkg.sv
rtl/cmta_select.sv
rtl/cmta_div_stage.sv
rtl/cube_map_texel_addressing.sv
dv/cmta_checker.sv
dv/testbench.sv
